// ===== design/rbot_pkg.sv =====
`default_nettype none

package rbot_pkg;

   localparam int RELAYS_DEFAULT      = 8;
   localparam int TIMER_WIDTH_DEFAULT = 16;

   typedef enum logic [2:0] {
      OP_SET_ON     = 3'd0,
      OP_SET_OFF    = 3'd1,
      OP_GET_STATUS = 3'd2,
      OP_SET_ALL    = 3'd3,
      OP_TICK       = 3'd4
   } opcode_type;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  relay_number;
      logic [15:0] on_seconds;
      logic [7:0]  all_on_mask;
      logic [7:0]  all_off_mask;
      logic [63:0] all_times;
      logic        all_well_formed;
   } req_type;

   typedef struct packed {
      logic       status_code;
      logic [7:0] read_value;
   } rsp_type;

   // Per-relay update request from the command decoder.
   typedef struct packed {
      logic set_on;
      logic clear;
      logic tick;
   } relay_cmd_type;

endpackage

`default_nettype wire

// ===== design/rbot_relay.sv =====
`default_nettype none

module rbot_relay #(
   parameter int TIMER_WIDTH = rbot_pkg::TIMER_WIDTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rbot_pkg::relay_cmd_type   cmd,
   input  wire logic [TIMER_WIDTH-1:0]    load_value,
   output logic                           relay_on,
   output logic                           armed
);

   logic                   on_ff, on_in;
   logic [TIMER_WIDTH-1:0] seconds_ff, seconds_in;

   always_comb begin
      on_in      = on_ff;
      seconds_in = seconds_ff;
      priority if (cmd.set_on) begin
         on_in      = 1'b1;
         seconds_in = load_value;
      end else if (cmd.clear) begin
         on_in      = 1'b0;
         seconds_in = '0;
      end else if (cmd.tick && (seconds_ff != '0)) begin
         seconds_in = seconds_ff - TIMER_WIDTH'(1);
         // The last second of the countdown switches the relay off.
         if (seconds_ff == TIMER_WIDTH'(1)) begin
            on_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff      <= 1'b0;
         seconds_ff <= '0;
      end else begin
         on_ff      <= on_in;
         seconds_ff <= seconds_in;
      end
   end

   assign relay_on = on_ff;
   assign armed    = (seconds_ff != '0);

endmodule

`default_nettype wire

// ===== design/relay_bank_with_off_timers.sv =====
// Bank of relays with per-relay auto-off countdown timers.
// The req channel carries decoded commands (set on, set off, get status,
// set all) and one-second ticks; every item gives exactly one item on the
// rsp channel with a status code and, for get status, the read value.
// Both channels use valid/stall; an item moves at a clock edge with valid
// high and stall low.
// An accepted item sits in an input register, where the command is decoded,
// all relays update in parallel and the response is formed; the response
// is then held in the result register. rsp_valid rises when the item moves
// from the input register to the result register, which a receiver stall
// can delay; one item is taken every cycle while the receiver does not stall.
// The single decode stage between the two registers sets that rate.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item; after that req_stall rises.
// Synchronous reset switches every relay off, disarms every timer and
// empties both registers.
`default_nettype none

module relay_bank_with_off_timers #(
   parameter int RELAYS      = rbot_pkg::RELAYS_DEFAULT,
   parameter int TIMER_WIDTH = rbot_pkg::TIMER_WIDTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rbot_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rbot_pkg::rsp_type      rsp_payload
);

   localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

   logic              in_valid_ff;
   rbot_pkg::req_type in_ff;
   logic              rsp_valid_ff;
   rbot_pkg::rsp_type rsp_ff, rsp_in;
   logic              advance;
   logic              fire;

   rbot_pkg::relay_cmd_type cmd [RELAYS];
   logic [TIMER_WIDTH-1:0]  load [RELAYS];
   logic [RELAYS-1:0]       relay_on;
   logic [RELAYS-1:0]       armed;
   logic [RELAYS-1:0]       sel;
   logic                    rel_bad;
   logic [TIMER_WIDTH-1:0]  set_on_time;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_payload;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      for (int i = 0; i < RELAYS; i++) begin
         sel[i] = (in_ff.relay_number == 4'(i + 1));
      end
      rel_bad = (in_ff.relay_number == 4'd0) || (in_ff.relay_number > 4'(RELAYS));
      if (32'(in_ff.on_seconds) > TIMER_MAX) begin
         set_on_time = TIMER_WIDTH'(TIMER_MAX);
      end else begin
         set_on_time = TIMER_WIDTH'(in_ff.on_seconds);
      end
   end

   // Decode: per-relay update requests and the response. The response reads
   // the relay state as it stands before this item's update.
   always_comb begin
      rsp_in.status_code = rbot_pkg::STATUS_OK;
      rsp_in.read_value  = 8'd0;
      for (int i = 0; i < RELAYS; i++) begin
         cmd[i]  = '0;
         load[i] = set_on_time;
      end
      unique case (in_ff.opcode)
         rbot_pkg::OP_SET_ON: begin
            if (rel_bad) begin
               rsp_in.status_code = rbot_pkg::STATUS_ERROR;
            end else begin
               for (int i = 0; i < RELAYS; i++) begin
                  cmd[i].set_on = fire && sel[i];
               end
            end
         end
         rbot_pkg::OP_SET_OFF: begin
            if (rel_bad) begin
               rsp_in.status_code = rbot_pkg::STATUS_ERROR;
            end else begin
               for (int i = 0; i < RELAYS; i++) begin
                  cmd[i].clear = fire && sel[i];
               end
            end
         end
         rbot_pkg::OP_GET_STATUS: begin
            if (in_ff.relay_number == 4'd0) begin
               rsp_in.read_value = 8'(relay_on);
            end else if (rel_bad) begin
               rsp_in.status_code = rbot_pkg::STATUS_ERROR;
            end else begin
               rsp_in.read_value = 8'(|(relay_on & sel));
            end
         end
         rbot_pkg::OP_SET_ALL: begin
            if (!in_ff.all_well_formed) begin
               rsp_in.status_code = rbot_pkg::STATUS_ERROR;
            end else begin
               for (int i = 0; i < RELAYS; i++) begin
                  cmd[i].set_on = fire && in_ff.all_on_mask[i];
                  cmd[i].clear  = fire && in_ff.all_off_mask[i];
                  load[i]       = TIMER_WIDTH'(in_ff.all_times[8*i +: 8]);
               end
            end
         end
         rbot_pkg::OP_TICK: begin
            for (int i = 0; i < RELAYS; i++) begin
               cmd[i].tick = fire;
            end
         end
         default: begin
            rsp_in.status_code = rbot_pkg::STATUS_ERROR;
         end
      endcase
   end

   for (genvar g = 0; g < RELAYS; g++) begin : g_relay
      rbot_relay #(
         .TIMER_WIDTH (TIMER_WIDTH)
      ) u_relay (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd[g]),
         .load_value (load[g]),
         .relay_on   (relay_on[g]),
         .armed      (armed[g])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // A relay that is off never has a running timer.
   a_off_not_armed: assert property (@(posedge clock) disable iff (reset)
      (armed & ~relay_on) == '0)
      else $error("relay off with an armed timer");

   // An accepted item always lands in the input register.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> in_valid_ff)
      else $error("accepted item lost");

   // A new response appears only when an item was waiting in the input register.
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("response without an item");
`endif

endmodule

`default_nettype wire

// ===== tb/relay_checker.sv =====
`timescale 1ns / 1ps

module relay_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  rbot_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rbot_pkg::rsp_type rsp_payload,
   output int                failures,
   output int                outstanding
);

   localparam int RELAYS      = rbot_pkg::RELAYS_DEFAULT;
   localparam int TIMER_WIDTH = rbot_pkg::TIMER_WIDTH_DEFAULT;

   logic                   relay_closed [RELAYS];
   logic [TIMER_WIDTH-1:0] countdown    [RELAYS];
   rbot_pkg::rsp_type      expected_replies [$];

   initial failures = 0;
   initial outstanding = 0;

   // Updates the relay model for one command and returns the reply it gives.
   function automatic rbot_pkg::rsp_type apply_command(rbot_pkg::req_type cmd);
      rbot_pkg::rsp_type reply;
      int                idx;
      reply.status_code = rbot_pkg::STATUS_OK;
      reply.read_value  = '0;
      case (cmd.opcode)
         rbot_pkg::OP_SET_ON, rbot_pkg::OP_SET_OFF: begin
            if (cmd.relay_number == 0 || cmd.relay_number > RELAYS) begin
               reply.status_code = rbot_pkg::STATUS_ERROR;
            end else begin
               idx = cmd.relay_number - 1;
               if (cmd.opcode == rbot_pkg::OP_SET_ON) begin
                  relay_closed[idx] = 1'b1;
                  countdown[idx]    = cmd.on_seconds;
               end else begin
                  relay_closed[idx] = 1'b0;
                  countdown[idx]    = '0;
               end
            end
         end
         rbot_pkg::OP_GET_STATUS: begin
            if (cmd.relay_number == 0) begin
               for (int i = 0; i < RELAYS; i++) reply.read_value[i] = relay_closed[i];
            end else if (cmd.relay_number <= RELAYS) begin
               reply.read_value[0] = relay_closed[cmd.relay_number - 1];
            end else begin
               reply.status_code = rbot_pkg::STATUS_ERROR;
            end
         end
         rbot_pkg::OP_SET_ALL: begin
            if (!cmd.all_well_formed) begin
               reply.status_code = rbot_pkg::STATUS_ERROR;
            end else begin
               // The on mask wins; a relay in neither mask is left alone.
               for (int i = 0; i < RELAYS; i++) begin
                  if (cmd.all_on_mask[i]) begin
                     relay_closed[i] = 1'b1;
                     countdown[i]    = TIMER_WIDTH'(cmd.all_times[8*i +: 8]);
                  end else if (cmd.all_off_mask[i]) begin
                     relay_closed[i] = 1'b0;
                     countdown[i]    = '0;
                  end
               end
            end
         end
         rbot_pkg::OP_TICK: begin
            for (int i = 0; i < RELAYS; i++) begin
               if (countdown[i] != 0) begin
                  countdown[i] = countdown[i] - 1'b1;
                  if (countdown[i] == 0) relay_closed[i] = 1'b0;
               end
            end
         end
         default: begin
            reply.status_code = rbot_pkg::STATUS_ERROR;
         end
      endcase
      return reply;
   endfunction

   always @(posedge clock) begin
      rbot_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < RELAYS; i++) begin
            relay_closed[i] = 1'b0;
            countdown[i]    = '0;
         end
         expected_replies.delete();
      end else begin
         if (req_valid && !req_stall) expected_replies.push_back(apply_command(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected reply, expected none, got status %0d value 0x%02h",
                        $time, rsp_payload.status_code, rsp_payload.read_value);
               failures++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_payload.status_code !== want.status_code) begin
                  $display("%0t: status_code expected %0d, got %0d",
                           $time, want.status_code, rsp_payload.status_code);
                  failures++;
               end
               if (rsp_payload.read_value !== want.read_value) begin
                  $display("%0t: read_value expected 0x%02h, got 0x%02h",
                           $time, want.read_value, rsp_payload.read_value);
                  failures++;
               end
            end
         end
      end
      outstanding <= expected_replies.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_ITEMS = 1530;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   rbot_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rbot_pkg::rsp_type rsp_payload;
   logic              quiet       = 1'b0;
   int                failure_count;
   int                outstanding;
   rbot_pkg::req_type cmd;

   always #5 clock = ~clock;

   relay_bank_with_off_timers u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   relay_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .failures    (failure_count),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 28);
   end

   function automatic rbot_pkg::req_type command(logic [2:0] op, logic [3:0] relay,
                                                 logic [15:0] secs);
      rbot_pkg::req_type c;
      c              = '0;
      c.opcode       = op;
      c.relay_number = relay;
      c.on_seconds   = secs;
      return c;
   endfunction

   // Mostly well-formed commands on valid relays with short timers, so that
   // ticks expire them; the other fields carry random noise.
   function automatic rbot_pkg::req_type random_command();
      rbot_pkg::req_type c;
      int                kind;
      c.opcode          = rbot_pkg::OP_TICK;
      c.relay_number    = 4'($urandom_range(15));
      c.on_seconds      = 16'($urandom_range(65535));
      c.all_on_mask     = 8'($urandom_range(255));
      c.all_off_mask    = 8'($urandom_range(255));
      c.all_times       = {$urandom, $urandom};
      c.all_well_formed = 1'($urandom_range(1));
      kind              = $urandom_range(99);
      if (kind < 18) begin
         c.opcode = rbot_pkg::OP_SET_ON;
         if ($urandom_range(9) != 0) begin
            c.relay_number = 4'($urandom_range(rbot_pkg::RELAYS_DEFAULT, 1));
         end
         case ($urandom_range(9))
            0:       c.on_seconds = 16'hFFFF;
            1:       c.on_seconds = '0;
            2, 3, 4: ;
            default: c.on_seconds = 16'($urandom_range(6));
         endcase
      end else if (kind < 28) begin
         c.opcode = rbot_pkg::OP_SET_OFF;
         if ($urandom_range(9) != 0) begin
            c.relay_number = 4'($urandom_range(rbot_pkg::RELAYS_DEFAULT, 1));
         end
      end else if (kind < 45) begin
         c.opcode = rbot_pkg::OP_GET_STATUS;
         case ($urandom_range(9))
            0, 1, 2: c.relay_number = '0;
            9:       ;
            default: c.relay_number = 4'($urandom_range(rbot_pkg::RELAYS_DEFAULT, 1));
         endcase
      end else if (kind < 60) begin
         c.opcode          = rbot_pkg::OP_SET_ALL;
         c.all_well_formed = ($urandom_range(9) != 0);
         if ($urandom_range(9) < 7) begin
            for (int i = 0; i < 8; i++) c.all_times[8*i +: 8] = 8'($urandom_range(6));
         end
      end else if (kind >= 95) begin
         c.opcode = 3'($urandom_range(7, rbot_pkg::OP_TICK + 1));
      end
      return c;
   endfunction

   task automatic send(input rbot_pkg::req_type c);
      while (!quiet && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_payload <= c;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send(command(rbot_pkg::OP_GET_STATUS, 4'd0, 16'd0));
      send(command(rbot_pkg::OP_SET_ON, 4'd1, 16'd0));
      send(command(rbot_pkg::OP_SET_ON, 4'd8, 16'hFFFF));
      send(command(rbot_pkg::OP_SET_ON, 4'd0, 16'd5));
      send(command(rbot_pkg::OP_SET_ON, 4'd9, 16'd5));
      send(command(rbot_pkg::OP_SET_OFF, 4'd15, 16'd0));
      send(command(rbot_pkg::OP_SET_OFF, 4'd0, 16'd0));
      send(command(rbot_pkg::OP_GET_STATUS, 4'd8, 16'd0));
      send(command(rbot_pkg::OP_GET_STATUS, 4'd15, 16'd0));
      send(command(rbot_pkg::OP_SET_ON, 4'd3, 16'd2));
      send(command(rbot_pkg::OP_TICK, 4'd0, 16'd0));
      send(command(rbot_pkg::OP_GET_STATUS, 4'd3, 16'd0));
      // Relay 3 expires here, while relay 1 has no timer and stays on.
      send(command(rbot_pkg::OP_TICK, 4'd0, 16'd0));
      send(command(rbot_pkg::OP_GET_STATUS, 4'd0, 16'd0));
      cmd                 = command(rbot_pkg::OP_SET_ALL, 4'd0, 16'd0);
      cmd.all_on_mask     = 8'hFF;
      cmd.all_well_formed = 1'b0;
      send(cmd);
      cmd                 = command(rbot_pkg::OP_SET_ALL, 4'd15, 16'd0);
      cmd.all_on_mask     = 8'h0F;
      cmd.all_off_mask    = 8'hFF;
      cmd.all_times       = 64'hFFFF_FFFF_0301_FF00;
      cmd.all_well_formed = 1'b1;
      send(cmd);
      send(command(rbot_pkg::OP_TICK, 4'd0, 16'd0));
      cmd                 = command(rbot_pkg::OP_SET_ALL, 4'd0, 16'd0);
      cmd.all_times       = '1;
      cmd.all_well_formed = 1'b1;
      send(cmd);
      send(command(rbot_pkg::OP_GET_STATUS, 4'd0, 16'd0));
      send(command(rbot_pkg::OP_SET_OFF, 4'd2, 16'd0));
      for (int op = rbot_pkg::OP_TICK + 1; op < 8; op++) send(command(3'(op), 4'd1, 16'd1));
      send(command(rbot_pkg::OP_GET_STATUS, 4'd2, 16'd0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 500) wait_drained();
         quiet <= (n >= 800 && n < 1100);
         send(random_command());
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (failure_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
